FILE: hw/rtl/gbr_pkg.sv
package gbr_pkg;

   // default geometry limits of the line stores
   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   // smallest frame dimension that is used
   localparam int MIN_DIM = 3;

   // configuration register widths and reset values
   localparam int LINE_WIDTH_W   = 12;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int START_ROW_W    = 11;
   localparam int BLUR_COUNT_W   = 23;
   localparam int CSR_DATA_W     = 23;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [START_ROW_W-1:0]    START_ROW_RESET    = 11'd1;
   localparam logic [BLUR_COUNT_W-1:0]   BLUR_COUNT_RESET   = 23'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_START_ROW,
      CSR_BLUR_COUNT
   } csr_index_type;

   // item modes
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic        mode;
      logic [31:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_out;
      logic        last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [LINE_WIDTH_W-1:0]   line_width;
      logic [FRAME_HEIGHT_W-1:0] frame_height;
      logic [START_ROW_W-1:0]    start_row;
      logic [BLUR_COUNT_W-1:0]   blur_count;
   } cfg_type;

   // per-transaction control passed from the front to the back
   typedef struct packed {
      logic store_en;
      logic emit;
      logic blur;
      logic last;
   } cmd_flags_type;

   localparam int CMD_FLAGS_W = $bits(cmd_flags_type);
   localparam int RSP_W       = $bits(rsp_type);

endpackage

FILE: hw/rtl/gaussian_blur_3x3_rgb.sv
// 3x3 gaussian blur on a raster ARGB stream, one transaction per clock while the result
// queue has room; a pixel's result is emitted by the transaction arriving one row and one
// pixel later, then passes the read, window and kernel stages into the result queue.
// the line stores allow one read and one write per cycle, which sets the one-per-clock rate.
// reset is synchronous and active high: counters, queues, window and registers clear;
// line store contents are left as they are and need no clearing pass.
module gaussian_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  gbr_pkg::req_type                  req_data,
   output logic                              empty,
   input  logic                              pop,
   output gbr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [gbr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CMD_W = 32 + AW + gbr_pkg::CMD_FLAGS_W;
   localparam int CCW   = $clog2(gbr_pkg::CMD_DEPTH + 1);

   gbr_pkg::cfg_type cfg_ff;
   logic             cmd_push;
   logic [CMD_W-1:0] cmd_push_data;
   logic             cmd_full;
   logic             cmd_pop;
   logic [CMD_W-1:0] cmd_pop_data;
   logic             cmd_empty;
   logic [CCW-1:0]   cmd_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width   <= gbr_pkg::LINE_WIDTH_RESET;
         cfg_ff.frame_height <= gbr_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.start_row    <= gbr_pkg::START_ROW_RESET;
         cfg_ff.blur_count   <= gbr_pkg::BLUR_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (gbr_pkg::csr_index_type'(csr_index))
            gbr_pkg::CSR_LINE_WIDTH: begin
               cfg_ff.line_width <= csr_wdata[gbr_pkg::LINE_WIDTH_W-1:0];
            end
            gbr_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= csr_wdata[gbr_pkg::FRAME_HEIGHT_W-1:0];
            end
            gbr_pkg::CSR_START_ROW: begin
               cfg_ff.start_row <= csr_wdata[gbr_pkg::START_ROW_W-1:0];
            end
            gbr_pkg::CSR_BLUR_COUNT: begin
               cfg_ff.blur_count <= csr_wdata[gbr_pkg::BLUR_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign full = cmd_full;

   // front: accepts and classifies transactions, tracks frame position
   gbr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .req_data (req_data),
      .in_full  (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_push_data)
   );

   // short command queue between front and back
   gbr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (gbr_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // back: line stores, window, kernel and result queue
   gbr_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty || (cmd_count == '0)),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_pop_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/gbr_ram.sv
module gbr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (old data on a collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gbr_fifo.sv
module gbr_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (32'(count_ff) == DEPTH);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : PTR_W'(32'(wr_ptr_ff) + 1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : PTR_W'(32'(rd_ptr_ff) + 1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(32'(count_ff) + 1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(32'(count_ff) - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/gbr_front.sv
module gbr_front #(
   parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gbr_pkg::cfg_type           cfg,
   input  logic                       push,
   input  gbr_pkg::req_type           req_data,
   input  logic                       in_full,
   output logic                       cmd_push,
   output logic [32 + $clog2(MAX_WIDTH) + gbr_pkg::CMD_FLAGS_W - 1:0] cmd_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int SW = gbr_pkg::START_ROW_W;
   localparam int BW = gbr_pkg::BLUR_COUNT_W;

   // clamped reset geometry
   localparam int W_RST_I = (int'(gbr_pkg::LINE_WIDTH_RESET) < gbr_pkg::MIN_DIM) ?
                            gbr_pkg::MIN_DIM :
                            (int'(gbr_pkg::LINE_WIDTH_RESET) > MAX_WIDTH) ?
                            MAX_WIDTH : int'(gbr_pkg::LINE_WIDTH_RESET);
   localparam int H_RST_I = (int'(gbr_pkg::FRAME_HEIGHT_RESET) < gbr_pkg::MIN_DIM) ?
                            gbr_pkg::MIN_DIM :
                            (int'(gbr_pkg::FRAME_HEIGHT_RESET) > MAX_HEIGHT) ?
                            MAX_HEIGHT : int'(gbr_pkg::FRAME_HEIGHT_RESET);
   localparam logic [WW-1:0] W_RESET = WW'(W_RST_I);
   localparam logic [HW-1:0] H_RESET = HW'(H_RST_I);

   // input position and frame state
   logic [WW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic [WW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic [BW-1:0] remaining_ff, remaining_in;
   logic [WW-1:0] cur_w_ff, cur_w_in;
   logic [HW-1:0] cur_h_ff, cur_h_in;
   logic [SW-1:0] cur_start_ff, cur_start_in;

   logic          accept;
   logic          in_tail;
   logic          frame_start;
   logic          flush_live;
   logic [WW-1:0] w_clamp;
   logic [HW-1:0] h_clamp;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [SW-1:0] start_eff;
   logic [BW-1:0] rem_eff;
   logic [PW-1:0] pend_eff;
   logic [WW-1:0] col_eff;
   logic [HW-1:0] row_eff;
   logic [WW-1:0] out_col_eff;
   logic [HW-1:0] out_row_eff;
   logic          emit;
   logic          interior;
   logic          do_blur;
   logic          is_last;
   logic [WW-1:0] col_next;
   logic [WW-1:0] out_col_next;
   logic [HW-1:0] out_row_next;
   gbr_pkg::cmd_flags_type flags;
   logic [31:0]   cmd_px;

   // geometry taken at frame start, clamped to the minimum dimension and the maximum size
   always_comb begin
      if (32'(cfg.line_width) < 32'(gbr_pkg::MIN_DIM)) begin
         w_clamp = WW'(gbr_pkg::MIN_DIM);
      end else if (32'(cfg.line_width) > 32'(MAX_WIDTH)) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(cfg.line_width);
      end
      if (32'(cfg.frame_height) < 32'(gbr_pkg::MIN_DIM)) begin
         h_clamp = HW'(gbr_pkg::MIN_DIM);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = HW'(cfg.frame_height);
      end
   end

   // classify the transaction
   assign accept      = push && !in_full;
   assign in_tail     = 32'(row_ff) >= 32'(cur_h_ff);
   assign frame_start = (req_data.mode == gbr_pkg::MODE_PIXEL) &&
                        (in_tail || (row_ff == '0 && col_ff == '0));
   assign flush_live  = (req_data.mode == gbr_pkg::MODE_FLUSH) && in_tail &&
                        (pending_ff != '0);

   // state as seen by this transaction
   always_comb begin
      w_eff       = frame_start ? w_clamp : cur_w_ff;
      h_eff       = frame_start ? h_clamp : cur_h_ff;
      start_eff   = frame_start ? cfg.start_row : cur_start_ff;
      rem_eff     = frame_start ? cfg.blur_count : remaining_ff;
      pend_eff    = frame_start ? '0 : pending_ff;
      col_eff     = frame_start ? '0 : col_ff;
      row_eff     = frame_start ? '0 : row_ff;
      out_col_eff = frame_start ? '0 : out_col_ff;
      out_row_eff = frame_start ? '0 : out_row_ff;
   end

   // output position, region test and frame-end marker
   always_comb begin
      emit = flush_live ||
             ((req_data.mode == gbr_pkg::MODE_PIXEL) &&
              (32'(pend_eff) >= 32'(w_eff) + 32'd1));
      interior = (out_row_eff != '0) && (32'(out_row_eff) + 32'd2 <= 32'(h_eff)) &&
                 (out_col_eff != '0) && (32'(out_col_eff) + 32'd2 <= 32'(w_eff));
      do_blur  = emit && interior && (32'(out_row_eff) >= 32'(start_eff)) &&
                 (rem_eff != '0);
      is_last  = (32'(out_row_eff) + 32'd1 == 32'(h_eff)) &&
                 (32'(out_col_eff) + 32'd1 == 32'(w_eff));
      out_col_next = WW'(32'(out_col_eff) + 32'd1);
      out_row_next = out_row_eff;
      if (32'(out_col_eff) + 32'd1 >= 32'(w_eff)) begin
         out_col_next = '0;
         if (32'(out_row_eff) + 32'd1 >= 32'(h_eff)) begin
            out_row_next = '0;
         end else begin
            out_row_next = HW'(32'(out_row_eff) + 32'd1);
         end
      end
      col_next = WW'(32'(col_eff) + 32'd1);
   end

   // command to the back end
   always_comb begin
      flags.store_en = 32'(col_eff) < 32'(w_eff);
      flags.emit     = emit;
      flags.blur     = do_blur;
      flags.last     = is_last;
      cmd_px   = (req_data.mode == gbr_pkg::MODE_PIXEL) ? req_data.pixel_in : 32'd0;
      cmd_data = {flags, col_eff[AW-1:0], cmd_px};
      cmd_push = accept && ((req_data.mode == gbr_pkg::MODE_PIXEL) || flush_live);
   end

   // next state
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      pending_in   = pending_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      remaining_in = remaining_ff;
      cur_w_in     = cur_w_ff;
      cur_h_in     = cur_h_ff;
      cur_start_in = cur_start_ff;
      if (accept && (req_data.mode == gbr_pkg::MODE_PIXEL)) begin
         cur_w_in     = w_eff;
         cur_h_in     = h_eff;
         cur_start_in = start_eff;
         remaining_in = rem_eff;
         pending_in   = pend_eff;
         out_col_in   = out_col_eff;
         out_row_in   = out_row_eff;
         if (32'(col_next) >= 32'(w_eff)) begin
            col_in = '0;
            row_in = HW'(32'(row_eff) + 32'd1);
         end else begin
            col_in = col_next;
            row_in = row_eff;
         end
         if (emit) begin
            out_col_in = out_col_next;
            out_row_in = out_row_next;
            if (do_blur) begin
               remaining_in = BW'(32'(rem_eff) - 32'd1);
            end
         end else begin
            pending_in = PW'(32'(pend_eff) + 32'd1);
         end
      end else if (accept && flush_live) begin
         out_col_in = out_col_next;
         out_row_in = out_row_next;
         if (do_blur) begin
            remaining_in = BW'(32'(remaining_ff) - 32'd1);
         end
         pending_in = PW'(32'(pending_ff) - 32'd1);
         if (32'(pending_ff) == 32'd1) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         pending_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         remaining_ff <= '0;
         cur_w_ff     <= W_RESET;
         cur_h_ff     <= H_RESET;
         cur_start_ff <= gbr_pkg::START_ROW_RESET;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         pending_ff   <= pending_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         remaining_ff <= remaining_in;
         cur_w_ff     <= cur_w_in;
         cur_h_ff     <= cur_h_in;
         cur_start_ff <= cur_start_in;
      end
   end

endmodule

FILE: hw/rtl/gbr_back.sv
module gbr_back #(
   parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   input  logic [32 + $clog2(MAX_WIDTH) + gbr_pkg::CMD_FLAGS_W - 1:0] cmd_data,
   output logic                  empty,
   input  logic                  pop,
   output gbr_pkg::rsp_type      rsp_data
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CMD_W = 32 + AW + gbr_pkg::CMD_FLAGS_W;
   localparam int OCW   = $clog2(gbr_pkg::OUT_DEPTH + 1);

   // queue head fields
   gbr_pkg::cmd_flags_type cmd_flags;
   logic [AW-1:0]          cmd_addr;
   logic [31:0]            cmd_px;

   // line store stage
   logic                   s1_valid_ff;
   gbr_pkg::cmd_flags_type s1_flags_ff;
   logic [AW-1:0]          s1_addr_ff;
   logic [31:0]            s1_px_ff;
   logic                   fwd_ff;
   logic [63:0]            fwd_data_ff;
   logic [63:0]            ram_rd_data;
   logic [63:0]            line_data;
   logic [31:0]            up_px;
   logic [31:0]            mid_px;
   logic                   fwd_in;

   // window stage
   logic [31:0]            win_ff [3][3];
   logic                   s2_valid_ff;
   logic                   s2_blur_ff;
   logic                   s2_last_ff;
   logic [9:0]             corner_sum [3];
   logic [9:0]             side_sum [3];

   // kernel stage
   logic                   s3_valid_ff;
   logic                   s3_blur_ff;
   logic                   s3_last_ff;
   logic [31:0]            s3_center_ff;
   logic [9:0]             s3_corner_ff [3];
   logic [9:0]             s3_side_ff [3];
   logic [11:0]            kern_sum [3];
   logic [31:0]            blur_px;
   gbr_pkg::rsp_type       out_item;

   // output queue
   logic                   out_full;
   logic [OCW-1:0]         out_count;
   logic [gbr_pkg::RSP_W-1:0] out_pop_data;
   logic [1:0]             inflight;

   assign cmd_flags = gbr_pkg::cmd_flags_type'(cmd_data[CMD_W-1 -: gbr_pkg::CMD_FLAGS_W]);
   assign cmd_addr  = cmd_data[32 +: AW];
   assign cmd_px    = cmd_data[31:0];

   // issue only when the output queue has room for everything in flight
   assign inflight = 2'(s1_valid_ff & s1_flags_ff.emit) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
   assign cmd_pop  = !cmd_empty &&
                     (32'(out_count) + 32'(inflight) < 32'(gbr_pkg::OUT_DEPTH));

   // line data: forwarded on a back-to-back hit, zero past the row end
   always_comb begin
      line_data = fwd_ff ? fwd_data_ff : ram_rd_data;
      up_px     = s1_flags_ff.store_en ? line_data[63:32] : 32'd0;
      mid_px    = s1_flags_ff.store_en ? line_data[31:0] : 32'd0;
      fwd_in    = cmd_pop && s1_valid_ff && s1_flags_ff.store_en &&
                  cmd_flags.store_en && (s1_addr_ff == cmd_addr);
   end

   // both line stores in one word: upper in the high half, middle in the low
   gbr_ram #(
      .WIDTH (64),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_flags_ff.store_en),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid_px, s1_px_ff}),
      .rd_addr (cmd_addr),
      .rd_data (ram_rd_data)
   );

   // read stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_pop;
         fwd_ff      <= fwd_in;
      end
      s1_flags_ff <= cmd_flags;
      s1_addr_ff  <= cmd_addr;
      s1_px_ff    <= cmd_px;
      fwd_data_ff <= {mid_px, s1_px_ff};
   end

   // window shift, one column per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= 32'd0;
            end
         end
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= up_px;
            win_ff[1][2] <= mid_px;
            win_ff[2][2] <= s1_px_ff;
         end
         s2_valid_ff <= s1_valid_ff && s1_flags_ff.emit;
      end
      s2_blur_ff <= s1_flags_ff.blur;
      s2_last_ff <= s1_flags_ff.last;
   end

   // partial sums per colour channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         corner_sum[ch] = 10'(win_ff[0][0][8*ch +: 8]) + 10'(win_ff[0][2][8*ch +: 8]) +
                          10'(win_ff[2][0][8*ch +: 8]) + 10'(win_ff[2][2][8*ch +: 8]);
         side_sum[ch]   = 10'(win_ff[0][1][8*ch +: 8]) + 10'(win_ff[2][1][8*ch +: 8]) +
                          10'(win_ff[1][0][8*ch +: 8]) + 10'(win_ff[1][2][8*ch +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_blur_ff   <= s2_blur_ff;
      s3_last_ff   <= s2_last_ff;
      s3_center_ff <= win_ff[1][1];
      for (int ch = 0; ch < 3; ch++) begin
         s3_corner_ff[ch] <= corner_sum[ch];
         s3_side_ff[ch]   <= side_sum[ch];
      end
   end

   // weighted sum and truncating shift, then pick filtered or passed pixel
   always_comb begin
      blur_px = {gbr_pkg::ALPHA_OPAQUE, 24'd0};
      for (int ch = 0; ch < 3; ch++) begin
         kern_sum[ch] = {2'b00, s3_center_ff[8*ch +: 8], 2'b00} +
                        {1'b0, s3_side_ff[ch], 1'b0} +
                        {2'b00, s3_corner_ff[ch]};
         blur_px[8*ch +: 8] = kern_sum[ch][11:4];
      end
      out_item.pixel_out     = s3_blur_ff ? blur_px : s3_center_ff;
      out_item.last_of_frame = s3_last_ff;
   end

   gbr_fifo #(
      .WIDTH (gbr_pkg::RSP_W),
      .DEPTH (gbr_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (out_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_pop_data),
      .empty     (empty),
      .count     (out_count)
   );

   // the issue credit keeps every push off a full queue; full gates the push and masks data only when also empty
   assign rsp_data = gbr_pkg::rsp_type'(out_pop_data & {gbr_pkg::RSP_W{!(out_full && empty)}});

endmodule

FILE: verif/gaussian_blur_3x3_rgb_tb.sv
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb_tb;

   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned BLUR_ALL     = 23'h7F_FFFF;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            push      = 1'b0;
   logic                            full;
   gbr_pkg::req_type                req_data  = '0;
   logic                            empty;
   logic                            pop       = 1'b0;
   gbr_pkg::rsp_type                rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [gbr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gbr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // expected output pixels, oldest first
   gbr_pkg::rsp_type expected_pixels [$];

   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned stall_cycles  = 0;
   int unsigned send_gap_max  = 13;
   int unsigned recv_gap_max  = 13;
   bit          hold_request  = 1'b0;

   // filter model state: registers, latched geometry, stores and window
   int unsigned reg_value [4] = '{640, 480, 1, 0};
   int unsigned frame_w = 640;
   int unsigned frame_h = 480;
   int unsigned frame_start_row = 1;
   int unsigned blurs_left = 0;
   int unsigned in_col = 0;
   int unsigned in_row = 0;
   int unsigned out_col = 0;
   int unsigned out_row = 0;
   int unsigned pending = 0;
   bit [31:0]   upper_line [gbr_pkg::MAX_WIDTH_DEFAULT];
   bit [31:0]   middle_line [gbr_pkg::MAX_WIDTH_DEFAULT];
   bit [31:0]   win [3][3];

   gaussian_blur_3x3_rgb uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < gbr_pkg::MIN_DIM) return gbr_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // shift one pixel into the window, rotating the line stores at this column
   function automatic void shift_window(input bit [31:0] px);
      bit [31:0] up;
      bit [31:0] mid;
      up = '0;
      mid = '0;
      if (in_col < frame_w) begin
         up = upper_line[in_col];
         mid = middle_line[in_col];
         upper_line[in_col] = mid;
         middle_line[in_col] = px;
      end
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
   endfunction

   // centre of the window leaves, filtered when inside the blur region
   function automatic void emit_pixel();
      gbr_pkg::rsp_type res;
      int               sum;
      bit               interior;
      interior = out_row >= 1 && out_row + 2 <= frame_h &&
                 out_col >= 1 && out_col + 2 <= frame_w;
      res.pixel_out = win[1][1];
      if (interior && out_row >= frame_start_row && blurs_left != 0) begin
         res.pixel_out[31:24] = gbr_pkg::ALPHA_OPAQUE;
         for (int sh = 0; sh < 24; sh += 8) begin
            sum = (int'(win[1][1][sh +: 8]) << 2)
                + ((int'(win[0][1][sh +: 8]) + int'(win[2][1][sh +: 8])
                  + int'(win[1][0][sh +: 8]) + int'(win[1][2][sh +: 8])) << 1)
                + int'(win[0][0][sh +: 8]) + int'(win[0][2][sh +: 8])
                + int'(win[2][0][sh +: 8]) + int'(win[2][2][sh +: 8]);
            res.pixel_out[sh +: 8] = 8'(sum >> 4);
         end
         blurs_left--;
      end
      res.last_of_frame = (out_row + 1 == frame_h) && (out_col + 1 == frame_w);
      expected_pixels.push_back(res);
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
         if (out_row >= frame_h) out_row = 0;
      end
   endfunction

   // advance the filter model by one accepted transaction
   function automatic void advance_blur_model(input gbr_pkg::req_type item);
      bit in_tail;
      in_tail = in_row >= frame_h;
      if (item.mode == gbr_pkg::MODE_FLUSH) begin
         // flush only counts while a frame tail is pending
         if (in_tail && pending != 0) begin
            shift_window(32'h0);
            in_col++;
            emit_pixel();
            pending--;
            if (pending == 0) begin
               in_row = 0;
               in_col = 0;
            end
         end
      end else begin
         // frame start: latch geometry, a pixel in the tail drops what is left
         if (in_tail || (in_row == 0 && in_col == 0)) begin
            frame_w = clamp_dim(reg_value[gbr_pkg::CSR_LINE_WIDTH],
                                gbr_pkg::MAX_WIDTH_DEFAULT);
            frame_h = clamp_dim(reg_value[gbr_pkg::CSR_FRAME_HEIGHT],
                                gbr_pkg::MAX_HEIGHT_DEFAULT);
            frame_start_row = reg_value[gbr_pkg::CSR_START_ROW];
            blurs_left = reg_value[gbr_pkg::CSR_BLUR_COUNT];
            pending = 0;
            out_col = 0;
            out_row = 0;
            in_row = 0;
            in_col = 0;
         end
         shift_window(item.pixel_in);
         in_col++;
         if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
         end
         if (pending >= frame_w + 1) emit_pixel();
         else pending++;
      end
   endfunction

   task automatic report_error(input string msg);
      $display("error at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // offer one transaction after a random gap and wait until it is taken
   task automatic send_item(input logic mode, input logic [31:0] pix);
      gbr_pkg::req_type item;
      int unsigned      gap;
      item.mode = mode;
      item.pixel_in = pix;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      advance_blur_model(item);
      items_sent++;
   endtask

   // stop offering, wait for every expected pixel and for the pipeline to empty
   task automatic settle_block();
      @(negedge clock);
      push <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, sometimes with junk above the field width
   task automatic write_csr(input gbr_pkg::csr_index_type idx, input int unsigned value);
      int unsigned fld_w;
      int unsigned data;
      case (idx)
         gbr_pkg::CSR_LINE_WIDTH:   fld_w = gbr_pkg::LINE_WIDTH_W;
         gbr_pkg::CSR_FRAME_HEIGHT: fld_w = gbr_pkg::FRAME_HEIGHT_W;
         gbr_pkg::CSR_START_ROW:    fld_w = gbr_pkg::START_ROW_W;
         default:                   fld_w = gbr_pkg::BLUR_COUNT_W;
      endcase
      data = value & ((1 << fld_w) - 1);
      if ($urandom_range(0, 3) == 0) data |= $urandom << fld_w;
      data &= (1 << gbr_pkg::CSR_DATA_W) - 1;
      @(negedge clock);
      push      <= 1'b0;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= gbr_pkg::CSR_DATA_W'(data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reg_value[idx] = data & ((1 << fld_w) - 1);
   endtask

   task automatic program_frame(input int unsigned cols, input int unsigned rows,
                                input int unsigned start, input int unsigned count);
      write_csr(gbr_pkg::CSR_LINE_WIDTH, cols);
      write_csr(gbr_pkg::CSR_FRAME_HEIGHT, rows);
      write_csr(gbr_pkg::CSR_START_ROW, start);
      write_csr(gbr_pkg::CSR_BLUR_COUNT, count);
   endtask

   // one full frame of pixels, optionally with stray flushes mixed in
   task automatic send_frame(input bit noisy);
      int unsigned total;
      logic [31:0] pix;
      total = clamp_dim(reg_value[gbr_pkg::CSR_LINE_WIDTH], gbr_pkg::MAX_WIDTH_DEFAULT) *
              clamp_dim(reg_value[gbr_pkg::CSR_FRAME_HEIGHT], gbr_pkg::MAX_HEIGHT_DEFAULT);
      for (int unsigned n = 0; n < total; n++) begin
         if (noisy && $urandom_range(0, 19) == 0) send_item(gbr_pkg::MODE_FLUSH, $urandom);
         case ($urandom_range(0, 7))
            0:       pix = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: pix = $urandom;
         endcase
         send_item(gbr_pkg::MODE_PIXEL, pix);
      end
   endtask

   // smallest frame with extreme pixels, ignored flushes, a cut tail and clamping
   task automatic test_directed_basics();
      // nothing pending: both flushes are ignored
      send_item(gbr_pkg::MODE_FLUSH, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_FLUSH, 32'h0);
      program_frame(3, 3, 1, BLUR_ALL);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      // mid-frame flush is ignored
      send_item(gbr_pkg::MODE_FLUSH, 32'h0);
      send_item(gbr_pkg::MODE_PIXEL, 32'h00FF_00FF);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      // only part of the tail, the next pixel drops the rest
      send_item(gbr_pkg::MODE_FLUSH, 32'h0);
      send_item(gbr_pkg::MODE_FLUSH, 32'h0);
      settle_block();
      // width and height below the minimum are clamped
      program_frame(0, 2, 1, 0);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'h1234_5678);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hA5A5_5A5A);
      send_item(gbr_pkg::MODE_PIXEL, 32'h0000_0000);
      send_item(gbr_pkg::MODE_PIXEL, 32'hFFFF_FFFF);
      repeat (4) send_item(gbr_pkg::MODE_FLUSH, 32'h0);
      // tail done: one more flush is ignored
      send_item(gbr_pkg::MODE_FLUSH, 32'hFFFF_FFFF);
   endtask

   // small random frames with random region settings and broken tails
   task automatic test_random_frames();
      int unsigned first_item;
      int unsigned cols;
      int unsigned rows;
      int unsigned cols_used;
      int unsigned rows_used;
      int unsigned start;
      int unsigned count;
      int unsigned tail;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         settle_block();
         case ($urandom_range(0, 9))
            0:       cols = $urandom_range(0, 2);
            1:       cols = $urandom_range(13, 40);
            default: cols = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 19))
            0, 1:    rows = $urandom_range(0, 2);
            2:       rows = $urandom_range(9, 16);
            default: rows = $urandom_range(3, 8);
         endcase
         cols_used = clamp_dim(cols, gbr_pkg::MAX_WIDTH_DEFAULT);
         rows_used = clamp_dim(rows, gbr_pkg::MAX_HEIGHT_DEFAULT);
         case ($urandom_range(0, 6))
            0:       start = 0;
            1:       start = $urandom_range(2046, 2047);
            default: start = $urandom_range(1, rows_used - 1);
         endcase
         case ($urandom_range(0, 7))
            0, 1:    count = 0;
            2:       count = BLUR_ALL;
            3:       count = 4194304;
            default: count = $urandom_range(1, cols_used * rows_used);
         endcase
         program_frame(cols, rows, start, count);
         send_gap_max = ($urandom_range(0, 5) == 0) ? 0 : 13;
         recv_gap_max = ($urandom_range(0, 5) == 0) ? 0 : 13;
         send_frame(1'b1);
         case ($urandom_range(0, 9))
            0, 1:    tail = $urandom_range(0, cols_used);
            2:       tail = cols_used + 1 + $urandom_range(1, 3);
            default: tail = cols_used + 1;
         endcase
         repeat (tail) send_item(gbr_pkg::MODE_FLUSH, $urandom);
      end
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      settle_block();
      program_frame(3, 8, 1, BLUR_ALL);
      send_gap_max = 0;
      hold_request = 1'b1;
      send_frame(1'b0);
      repeat (4) send_item(gbr_pkg::MODE_FLUSH, $urandom);
      send_gap_max = 13;
      recv_gap_max = 13;
   endtask

   // wide single interior row with a count of 4194304, region on the last interior row
   task automatic test_region_edges();
      settle_block();
      program_frame(40, 3, 1, 4194304);
      send_frame(1'b0);
      repeat (41) send_item(gbr_pkg::MODE_FLUSH, $urandom);
      settle_block();
      program_frame(3, 12, 10, BLUR_ALL);
      send_frame(1'b0);
      repeat (4) send_item(gbr_pkg::MODE_FLUSH, $urandom);
   endtask

   // result side: random gaps before each transaction, one long hold on request
   initial begin : drain_results
      int unsigned gap;
      wait (!reset);
      forever begin
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            gap = $urandom_range(0, recv_gap_max);
         end
         @(negedge clock);
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   // compare every accepted result with the oldest expected pixel
   always @(posedge clock) begin : check_results
      gbr_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("unexpected pixel %h", rsp_data.pixel_out));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out)
               report_error($sformatf("pixel_out %h, expected %h",
                                      rsp_data.pixel_out, want.pixel_out));
            if (rsp_data.last_of_frame !== want.last_of_frame)
               report_error($sformatf("last_of_frame %b, expected %b",
                                      rsp_data.last_of_frame, want.last_of_frame));
         end
      end
   end

   // cycles without any transaction on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_random_frames();
      test_backpressure();
      test_region_edges();
      settle_block();
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
